// File: hdl/lcg16_pkg.sv
package lcg16_pkg;

    // Generator constants: x' = (LCG_MUL * x + LCG_INC) mod 2^16
    localparam int          VAL_W   = 16;
    localparam int          STEP_W  = 32;
    localparam logic [15:0] LCG_MUL = 16'd25173;
    localparam logic [15:0] LCG_INC = 16'd13849;

    // Default width of the step limit that is honored
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration register map
    localparam int         CFG_IDX_W   = 8;
    localparam logic [7:0] CFG_BOUND_A = 8'd0;
    localparam logic [7:0] CFG_BOUND_B = 8'd1;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_SEED   = 2'd0,
        REQ_STEP   = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step_en;
        logic mod_init;
        logic mod_en;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic step_done;
        logic mod_last;
        logic out_free;
    } sts_t;

    // One generator step, truncated to 16 bits
    function automatic logic [15:0] lcg_next(input logic [15:0] x);
        logic [15:0] prod;
        prod     = x * LCG_MUL;
        lcg_next = prod + LCG_INC;
    endfunction

endpackage

// File: hdl/lcg16_generator_with_range_core.sv
// 16-bit linear congruential generator, x' = (25173*x + 13849) mod 65536, with
// range mapping. A request (kind in s_tuser) either seeds the generator and
// skips step_limit steps, takes one step, or searches forward from a seed for
// a target within step_limit steps without touching the generator state. Each
// request gives one result: the value, the current value mapped into
// [min(bound_a,bound_b), max(...)] by a modulo, the step count since the last
// seed, the steps this request took and a found flag. One request is in work
// at a time. A request does N generator steps (step_limit for seed-and-skip, 1
// for a single step, up to step_limit for a search, 0 otherwise): one step per
// cycle in the step loop; then the bit-serial remainder unit reduces the value,
// and the output register is loaded once it is free. cfg_ready is always high.
// A new request is taken the cycle after the result is loaded into the output
// register, which may still wait for m_tready. The user must write the bounds
// through the cfg port (index 0 and 1) only while no request is in work; the
// block itself does not enforce it.
module lcg16_generator_with_range_core #(
    parameter int COUNT_WIDTH = lcg16_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // seed, step_limit, target
    input  logic [1:0]                      s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value, ranged_value, step_count, iterations
    output logic [79:0]                     m_tdata,
    output logic [0:0]                      m_tuser,   // found
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lcg16_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);
    import lcg16_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  ranged_value;
    logic [STEP_W-1:0] step_count;
    logic [VAL_W-1:0]  iterations;
    logic              found;

    assign cfg_ready = 1'b1;

    lcg16_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcg16_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (s_tuser),
        .seed         (s_tdata[15:0]),
        .step_limit   (s_tdata[31:16]),
        .target       (s_tdata[47:32]),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .value        (value),
        .ranged_value (ranged_value),
        .step_count   (step_count),
        .iterations   (iterations),
        .found        (found)
    );

    assign m_tdata = {iterations, step_count, ranged_value, value};
    assign m_tuser = found;

endmodule

// File: hdl/lcg16_ctrl.sv
module lcg16_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lcg16_pkg::sts_t sts,
    output lcg16_pkg::cmd_t cmd
);
    import lcg16_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_MOD  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Issue commands and pick the next state
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (sts.step_done) begin
                    cmd.mod_init = 1'b1;
                    state_next   = ST_MOD;
                end else begin
                    cmd.step_en = 1'b1;
                end
            end
            ST_MOD: begin
                cmd.mod_en = 1'b1;
                if (sts.mod_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/lcg16_dp.sv
module lcg16_dp #(
    parameter int COUNT_WIDTH = lcg16_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lcg16_pkg::cmd_t                cmd,
    output lcg16_pkg::sts_t                sts,
    input  logic [1:0]                     req_type,
    input  logic [lcg16_pkg::VAL_W-1:0]    seed,
    input  logic [lcg16_pkg::VAL_W-1:0]    step_limit,
    input  logic [lcg16_pkg::VAL_W-1:0]    target,
    input  logic                           cfg_valid,
    input  logic [lcg16_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcg16_pkg::VAL_W-1:0]    cfg_data,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [lcg16_pkg::VAL_W-1:0]    value,
    output logic [lcg16_pkg::VAL_W-1:0]    ranged_value,
    output logic [lcg16_pkg::STEP_W-1:0]   step_count,
    output logic [lcg16_pkg::VAL_W-1:0]    iterations,
    output logic                           found
);
    import lcg16_pkg::*;

    // Only the low bits of the limit that fit both the parameter and the field count
    localparam int IterW = (COUNT_WIDTH < VAL_W) ? COUNT_WIDTH : VAL_W;

    req_t              req_reg;
    logic [IterW-1:0]  lim_reg;
    logic [IterW-1:0]  iter_reg;
    logic [VAL_W-1:0]  tgt_reg;
    logic [VAL_W-1:0]  cur_reg;
    logic [VAL_W-1:0]  srch_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [VAL_W-1:0]  bound_a_reg;
    logic [VAL_W-1:0]  bound_b_reg;
    logic [VAL_W:0]    rem_reg;
    logic [3:0]        bit_reg;
    logic              m_tvalid_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [VAL_W-1:0]  ranged_reg;
    logic [STEP_W-1:0] step_count_reg;
    logic [VAL_W-1:0]  iterations_reg;
    logic              found_reg;

    logic [IterW-1:0]  lim_in;
    logic              hit;
    logic              a_lt_b;
    logic [VAL_W-1:0]  lo_w;
    logic [VAL_W-1:0]  hi_w;
    logic [VAL_W:0]    span_w;
    logic [VAL_W:0]    shifted_w;
    logic [VAL_W:0]    trial_w;

    // Limit per request kind: a single step is a one-step run, unused codes run none
    always_comb begin
        case (req_type)
            REQ_SEED, REQ_SEARCH: lim_in = step_limit[IterW-1:0];
            REQ_STEP:             lim_in = IterW'(1);
            default:              lim_in = '0;
        endcase
    end

    assign hit = (req_reg == REQ_SEARCH) && (srch_reg == tgt_reg);

    // Range bounds: floor, ceiling and divisor (1 .. 65536)
    assign a_lt_b    = $signed(bound_a_reg) < $signed(bound_b_reg);
    assign lo_w      = a_lt_b ? bound_a_reg : bound_b_reg;
    assign hi_w      = a_lt_b ? bound_b_reg : bound_a_reg;
    assign span_w    = {hi_w[VAL_W-1], hi_w} - {lo_w[VAL_W-1], lo_w} + (VAL_W+1)'(1);

    // One restoring remainder step per cycle, MSB of the value first
    assign shifted_w = {rem_reg[VAL_W-1:0], cur_reg[bit_reg]};
    assign trial_w   = shifted_w - span_w;

    assign sts.step_done = (iter_reg == lim_reg) || hit;
    assign sts.mod_last  = (bit_reg == 4'd0);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_a_reg <= '0;
            bound_b_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_BOUND_A) begin
                bound_a_reg <= cfg_data;
            end
            if (cfg_index == CFG_BOUND_B) begin
                bound_b_reg <= cfg_data;
            end
        end
    end

    // Generator state: current value and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.load && (req_type == REQ_SEED)) begin
            cur_reg <= seed;
            cnt_reg <= '0;
        end else if (cmd.step_en && (req_reg != REQ_SEARCH)) begin
            cur_reg <= lcg_next(cur_reg);
            cnt_reg <= cnt_reg + STEP_W'(1);
        end
    end

    // Request capture and the step loop
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= req_t'(req_type);
            lim_reg  <= lim_in;
            tgt_reg  <= target;
            srch_reg <= seed;
            iter_reg <= '0;
        end else if (cmd.step_en) begin
            iter_reg <= iter_reg + IterW'(1);
            if (req_reg == REQ_SEARCH) begin
                srch_reg <= lcg_next(srch_reg);
            end
        end
    end

    // Remainder unit
    always_ff @(posedge aclk) begin
        if (cmd.mod_init) begin
            rem_reg <= '0;
            bit_reg <= 4'(VAL_W - 1);
        end else if (cmd.mod_en) begin
            rem_reg <= (shifted_w >= span_w) ? trial_w : shifted_w;
            bit_reg <= bit_reg - 4'd1;
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            value_reg      <= (req_reg == REQ_SEARCH) ? srch_reg : cur_reg;
            ranged_reg     <= rem_reg[VAL_W-1:0] + lo_w;
            step_count_reg <= cnt_reg;
            iterations_reg <= VAL_W'(iter_reg);
            found_reg      <= hit;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign value        = value_reg;
    assign ranged_value = ranged_reg;
    assign step_count   = step_count_reg;
    assign iterations   = iterations_reg;
    assign found        = found_reg;

endmodule

// File: hdl/lcg16_chk.sv
module lcg16_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // No result comes out of reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // One request at a time: busy the cycle after a request is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

endmodule

bind lcg16_generator_with_range_core lcg16_chk u_chk (.*);

// File: verif/tb_lcg16_generator_with_range_core.sv
`timescale 1ns / 100ps

module tb_lcg16_generator_with_range_core;
    import lcg16_pkg::*;

    localparam int          CNT_W        = COUNT_WIDTH_DEF;
    localparam logic [31:0] CNT_MASK     = 32'((64'd1 << CNT_W) - 64'd1);
    localparam int          IDLE_LIMIT   = 262144;
    localparam int          SETTLE_CYC   = 25;
    localparam int          LONG_HOLD    = 300;
    localparam int          PHASE_ITEMS  = 95;
    localparam int          FIXED_PHASES = 8;
    localparam int          PHASE_CNT    = 12;

    typedef struct {
        logic [15:0] value;
        logic [15:0] ranged;
        logic [31:0] steps;
        logic [15:0] iters;
        logic        found;
    } lcg_result_t;

    // Generator state mirror and the queue of results still owed by the block
    class lcg_result_board;
        logic [15:0]        cur_value;
        logic [31:0]        step_total;
        logic signed [15:0] bound_a;
        logic signed [15:0] bound_b;
        lcg_result_t        expected_q[$];
        int                 fail_cnt;

        function new();
            cur_value  = '0;
            step_total = '0;
            bound_a    = '0;
            bound_b    = '0;
            fail_cnt   = 0;
        endfunction

        static function logic [15:0] next_value(logic [15:0] x);
            logic [31:0] prod;
            prod = 32'(x) * 32'd25173 + 32'd13849;
            return prod[15:0];
        endfunction

        static function logic [15:0] advance(logic [15:0] x, int unsigned n);
            logic [15:0] v;
            v = x;
            for (int unsigned i = 0; i < n; i++) v = next_value(v);
            return v;
        endfunction

        function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == CFG_BOUND_A) bound_a = data;
            else if (idx == CFG_BOUND_B) bound_b = data;
        endfunction

        // Fold the current value into [min, max] of the two bounds
        function logic [15:0] fold_into_range(logic [15:0] x);
            int lo, hi, span, r;
            lo   = (bound_a < bound_b) ? int'(bound_a) : int'(bound_b);
            hi   = (bound_a < bound_b) ? int'(bound_b) : int'(bound_a);
            span = hi - lo + 1;
            r    = int'({16'd0, x}) % span + lo;
            return r[15:0];
        endfunction

        function void take_request(req_t kind, logic [15:0] seed, logic [15:0] limit,
                                   logic [15:0] target);
            lcg_result_t  res;
            logic [15:0]  x;
            int unsigned  n;
            int unsigned  cnt;
            n         = 32'(limit) & CNT_MASK;
            cnt       = 0;
            res.found = 1'b0;
            case (kind)
                REQ_SEED: begin
                    cur_value  = advance(seed, n);
                    step_total = n;
                    cnt        = n;
                    res.value  = cur_value;
                end
                REQ_STEP: begin
                    cur_value  = next_value(cur_value);
                    step_total = step_total + 1;
                    cnt        = 1;
                    res.value  = cur_value;
                end
                REQ_SEARCH: begin
                    // Walk from the seed; state stays untouched
                    x = seed;
                    while (cnt < n && x != target) begin
                        x   = next_value(x);
                        cnt = cnt + 1;
                    end
                    res.found = (x == target);
                    res.value = x;
                end
                default: begin
                    res.value = cur_value;
                end
            endcase
            res.iters  = cnt[15:0];
            res.ranged = fold_into_range(cur_value);
            res.steps  = step_total;
            expected_q = {expected_q, res};
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
                fail_cnt++;
            end
        endfunction

        function void check_result(logic [79:0] data, logic found_bit);
            lcg_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: data %0h found %0b", data, found_bit);
                fail_cnt++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("value", 32'(exp_r.value), 32'(data[15:0]));
            compare_field("ranged_value", 32'(exp_r.ranged), 32'(data[31:16]));
            compare_field("step_count", exp_r.steps, data[63:32]);
            compare_field("iterations", 32'(exp_r.iters), 32'(data[79:64]));
            compare_field("found", 32'(exp_r.found), 32'(found_bit));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;   // seed, step_limit, target
    logic [1:0]           s_tuser;   // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [79:0]          m_tdata;   // value, ranged_value, step_count, iterations
    logic [0:0]           m_tuser;   // found
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    lcg_result_board board;
    bit              quiet_phase;
    bit              hold_results;
    int              idle_cycles;

    lcg16_generator_with_range_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int draw_gap();
        return quiet_phase ? 0 : $urandom_range(0, 3);
    endfunction

    // Observe every handshake and feed the board
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.set_bound(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.take_request(req_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                                   s_tdata[47:32]);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_results) begin
                stall        = LONG_HOLD;
                hold_results = 1'b0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(req_t kind, logic [15:0] seed, logic [15:0] limit,
                                logic [15:0] target);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {target, limit, seed};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_requests();
        s_tvalid <= 1'b0;
    endtask

    // Write both bounds back to back; valid stays high across the pair
    task automatic write_bounds(logic [15:0] a, logic [15:0] b);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BOUND_A;
        cfg_data  <= a;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_BOUND_B;
        cfg_data  <= b;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Step past the last accept edge so its request is on the board, then drain
    task automatic wait_drained();
        @(posedge aclk);
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Mostly short runs; now and then a full 16-bit limit
    task automatic send_random_request();
        int           pick;
        int           sel;
        logic [15:0]  seed;
        logic [15:0]  limit;
        logic [15:0]  target;
        pick   = $urandom_range(0, 99);
        seed   = 16'($urandom);
        target = 16'($urandom);
        limit  = ($urandom_range(0, 127) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (pick < 30) begin
            send_request(REQ_SEED, seed, limit, target);
        end else if (pick < 60) begin
            send_request(REQ_STEP, seed, limit, target);
        end else if (pick < 95) begin
            // Hit within the limit, just past it, or any value
            sel = $urandom_range(0, 9);
            if (sel < 7)
                target = lcg_result_board::advance(seed, $urandom_range(0, int'(limit)));
            else if (sel < 9)
                target = lcg_result_board::advance(seed, int'(limit) + 1);
            send_request(REQ_SEARCH, seed, limit, target);
        end else begin
            send_request(REQ_NONE, seed, limit, target);
        end
    endtask

    initial begin
        logic signed [15:0] phase_a[FIXED_PHASES];
        logic signed [15:0] phase_b[FIXED_PHASES];
        logic [15:0]        x;
        logic [15:0]        bnd_a;
        logic [15:0]        bnd_b;
        phase_a = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd32768,
                    16'sd32767, -16'sd1, 16'sd100, 16'sd0};
        phase_b = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd32768,
                    16'sd32767, 16'sd1, -16'sd7, 16'sd32767};
        board        = new();
        quiet_phase  = 1'b0;
        hold_results = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_NONE;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BOUND_A;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset bounds
        send_request(REQ_STEP, 16'd0, 16'd0, 16'd0);
        send_request(REQ_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(REQ_SEED, 16'd0, 16'd0, 16'd0);
        send_request(REQ_SEED, 16'hFFFF, 16'd1, 16'd0);
        send_request(REQ_SEED, 16'd12345, 16'hFFFF, 16'd0);
        send_request(REQ_STEP, 16'd0, 16'd0, 16'd0);
        send_request(REQ_SEARCH, 16'd0, 16'd0, 16'd0);
        send_request(REQ_SEARCH, 16'hFFFF, 16'd0, 16'd0);
        send_request(REQ_SEARCH, 16'd1, 16'hFFFF, 16'hFFFF);
        x = 16'd4242;
        send_request(REQ_SEARCH, x, 16'd10, lcg_result_board::advance(x, 10));
        send_request(REQ_SEARCH, x, 16'd10, lcg_result_board::advance(x, 11));
        send_request(REQ_SEED, 16'd0, 16'd3, 16'hFFFF);
        send_request(REQ_NONE, 16'd0, 16'd0, 16'd0);
        stop_requests();
        wait_drained();

        // Random phases, each with its own bound setting
        for (int p = 0; p < PHASE_CNT; p++) begin
            if (p < FIXED_PHASES) begin
                bnd_a = phase_a[p];
                bnd_b = phase_b[p];
            end else begin
                bnd_a = 16'($urandom);
                bnd_b = 16'($urandom);
            end
            write_bounds(bnd_a, bnd_b);
            quiet_phase = (p % 3 == 1);
            if (p == 2) hold_results = 1'b1;
            repeat (PHASE_ITEMS) send_random_request();
            stop_requests();
            wait_drained();
        end

        if (board.fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
